@@ rtl/core/button_debounce_press_classifier_defines.svh @@
// Assertion macros for the button debounce press classifier.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BDPC_ASSERT_NOW(label, cond, expect_cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_cond)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BDPC_ASSERT_NEXT(label, cond, expect_cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_cond)) \
    else $error(msg);

`endif

@@ rtl/core/bdpc_pkg.sv @@
// Shared types and constants for the button debounce press classifier.
// No dependencies; imported by every module of the block.
package bdpc_pkg;

  localparam int TIME_BITS      = 32;
  localparam int COUNT_BITS     = 32;
  localparam int TOTAL_BITS     = 32;
  localparam int GUARD_BITS     = 16;
  localparam int DEBOUNCE_BITS  = 8;
  localparam int TICKS_BITS     = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [GUARD_BITS-1:0] guard_t;

  localparam guard_t GUARD_MAX = '1;

  // Register indexes on the config port
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE    = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STARTUP     = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_WIN  = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS  = 8'd3;

  // Reset values of the config registers
  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RST   = 8'd4;
  localparam logic [TICKS_BITS-1:0]    STARTUP_RST    = 16'd100;
  localparam logic [TICKS_BITS-1:0]    DOUBLE_WIN_RST = 16'd35;
  localparam logic [TICKS_BITS-1:0]    LONG_PRESS_RST = 16'd200;

  typedef struct packed {
    logic [DEBOUNCE_BITS-1:0] debounce_ticks;
    logic [TICKS_BITS-1:0]    startup_ticks;
    logic [TICKS_BITS-1:0]    double_window_ticks;
    logic [TICKS_BITS-1:0]    long_press_ticks;
  } cfg_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef struct packed {
    event_t                event_code;
    logic                  pressed_level;
    logic [TOTAL_BITS-1:0] short_total;
    logic [TOTAL_BITS-1:0] double_total;
    logic [TOTAL_BITS-1:0] long_total;
  } result_t;

endpackage

@@ rtl/core/bdpc_core.sv @@
// Debounce and press classification state with its single-pass next-state logic.
// Depends on bdpc_pkg. Produces the result of the current beat combinationally.
module bdpc_core
  import bdpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  logic    sample,
  input  cfg_t    cfg,
  output result_t result
);

  // State
  time_t  tick_now;
  guard_t guard_count;
  logic   loaded_flag;
  logic   raw_level;
  logic   stable_level;
  logic   long_reported;
  logic   short_pending;
  time_t  raw_change_time;
  time_t  press_time;
  time_t  release_time;
  count_t short_count;
  count_t double_count;
  count_t long_count;

  time_t  tick_now_next;
  guard_t guard_count_next;
  logic   loaded_flag_next;
  logic   raw_level_next;
  logic   stable_level_next;
  logic   long_reported_next;
  logic   short_pending_next;
  time_t  raw_change_time_next;
  time_t  press_time_next;
  time_t  release_time_next;
  count_t short_count_next;
  count_t double_count_next;
  count_t long_count_next;

  // Elapsed times against the updated stamps
  time_t  raw_elapsed;
  time_t  press_elapsed;
  time_t  release_elapsed;
  event_t ev;

  // Next-state logic for one tick
  always_comb begin
    tick_now_next        = tick_now + 1'b1;
    guard_count_next     = (guard_count == GUARD_MAX) ? guard_count : guard_count + 1'b1;
    loaded_flag_next     = loaded_flag;
    raw_level_next       = raw_level;
    stable_level_next    = stable_level;
    long_reported_next   = long_reported;
    short_pending_next   = short_pending;
    raw_change_time_next = raw_change_time;
    press_time_next      = press_time;
    release_time_next    = release_time;
    short_count_next     = short_count;
    double_count_next    = double_count;
    long_count_next      = long_count;
    raw_elapsed          = tick_now_next - raw_change_time;
    press_elapsed        = tick_now_next - press_time;
    release_elapsed      = tick_now_next - release_time;
    ev                   = EV_NONE;

    if (guard_count_next < cfg.startup_ticks) begin
      // startup guard: sample ignored
    end else if (!loaded_flag) begin
      // first tick past the guard loads the levels
      raw_level_next       = sample;
      stable_level_next    = sample;
      raw_change_time_next = tick_now_next;
      press_time_next      = sample ? tick_now_next : '0;
      loaded_flag_next     = 1'b1;
    end else begin
      if (sample != raw_level) begin
        raw_level_next       = sample;
        raw_change_time_next = tick_now_next;
        raw_elapsed          = '0;
      end

      // debounced edge
      if ((raw_level_next != stable_level) &&
          (raw_elapsed >= TIME_BITS'(cfg.debounce_ticks))) begin
        stable_level_next = raw_level_next;
        if (raw_level_next) begin
          press_time_next    = tick_now_next;
          press_elapsed      = '0;
          long_reported_next = 1'b0;
        end else if (!long_reported) begin
          if (short_pending &&
              (release_elapsed <= TIME_BITS'(cfg.double_window_ticks))) begin
            short_pending_next = 1'b0;
            double_count_next  = double_count + 1'b1;
            ev                 = EV_DOUBLE;
          end else begin
            short_pending_next = 1'b1;
            release_time_next  = tick_now_next;
            release_elapsed    = '0;
          end
        end
      end

      // long hold
      if (stable_level_next && !long_reported_next &&
          (press_elapsed >= TIME_BITS'(cfg.long_press_ticks))) begin
        long_reported_next = 1'b1;
        short_pending_next = 1'b0;
        long_count_next    = long_count + 1'b1;
        ev                 = EV_LONG;
      end

      // pending short expires after the window
      if (short_pending_next && !stable_level_next &&
          (release_elapsed > TIME_BITS'(cfg.double_window_ticks))) begin
        short_pending_next = 1'b0;
        short_count_next   = short_count + 1'b1;
        ev                 = EV_SHORT;
      end
    end
  end

  // Result of this beat
  always_comb begin
    result.event_code    = ev;
    result.pressed_level = stable_level_next;
    result.short_total   = TOTAL_BITS'(short_count_next);
    result.double_total  = TOTAL_BITS'(double_count_next);
    result.long_total    = TOTAL_BITS'(long_count_next);
  end

  // State registers advance once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now        <= '0;
      guard_count     <= '0;
      loaded_flag     <= 1'b0;
      raw_level       <= 1'b0;
      stable_level    <= 1'b0;
      long_reported   <= 1'b0;
      short_pending   <= 1'b0;
      raw_change_time <= '0;
      press_time      <= '0;
      release_time    <= '0;
      short_count     <= '0;
      double_count    <= '0;
      long_count      <= '0;
    end else if (accept) begin
      tick_now        <= tick_now_next;
      guard_count     <= guard_count_next;
      loaded_flag     <= loaded_flag_next;
      raw_level       <= raw_level_next;
      stable_level    <= stable_level_next;
      long_reported   <= long_reported_next;
      short_pending   <= short_pending_next;
      raw_change_time <= raw_change_time_next;
      press_time      <= press_time_next;
      release_time    <= release_time_next;
      short_count     <= short_count_next;
      double_count    <= double_count_next;
      long_count      <= long_count_next;
    end
  end

endmodule

@@ rtl/core/bdpc_out_buf.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on bdpc_pkg for the result beat type.
module bdpc_out_buf
  import bdpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_load,
  input  result_t in_beat,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_beat
);

  logic    skid_valid;
  result_t skid_beat;
  logic    out_free;

  assign full     = skid_valid;
  assign out_free = !out_valid || !out_stall;

  // Control: skid drains into the output register first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_load;
      skid_valid <= 1'b0;
    end else if (in_load) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_beat <= skid_valid ? skid_beat : in_beat;
    end else if (in_load) begin
      skid_beat <= in_beat;
    end
  end

endmodule

@@ rtl/core/button_debounce_press_classifier.sv @@
// Each accepted beat's result is registered in the two-entry buffer's output register,
// or in its skid register while results stall, letting one more sample in. Throughput:
// one sample per cycle while the skid is empty; the state update is one pass of
// compares and adds. Reset clears all timing state and totals, empties the buffer,
// and loads the config registers with their defaults; no clearing pass is needed.
module button_debounce_press_classifier
  import bdpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic                      pressed_sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [1:0]                event_code,
  output logic                      pressed_level,
  output logic [TOTAL_BITS-1:0]     short_total,
  output logic [TOTAL_BITS-1:0]     double_total,
  output logic [TOTAL_BITS-1:0]     long_total
);

`include "button_debounce_press_classifier_defines.svh"

  cfg_t    cfg;
  logic    accept;
  logic    buf_full;
  result_t core_beat;
  result_t out_beat;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= DEBOUNCE_RST;
      cfg.startup_ticks       <= STARTUP_RST;
      cfg.double_window_ticks <= DOUBLE_WIN_RST;
      cfg.long_press_ticks    <= LONG_PRESS_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_DEBOUNCE) begin
        cfg.debounce_ticks <= cfg_data[DEBOUNCE_BITS-1:0];
      end
      if (cfg_index == REG_STARTUP) begin
        cfg.startup_ticks <= cfg_data[TICKS_BITS-1:0];
      end
      if (cfg_index == REG_DOUBLE_WIN) begin
        cfg.double_window_ticks <= cfg_data[TICKS_BITS-1:0];
      end
      if (cfg_index == REG_LONG_PRESS) begin
        cfg.long_press_ticks <= cfg_data[TICKS_BITS-1:0];
      end
    end
  end

  assign sample_stall = buf_full;
  assign accept       = sample_valid && !sample_stall;

  bdpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (pressed_sample),
    .cfg    (cfg),
    .result (core_beat)
  );

  bdpc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_load   (accept),
    .in_beat   (core_beat),
    .full      (buf_full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_beat  (out_beat)
  );

  // Result ports
  assign event_code    = out_beat.event_code;
  assign pressed_level = out_beat.pressed_level;
  assign short_total   = out_beat.short_total;
  assign double_total  = out_beat.double_total;
  assign long_total    = out_beat.long_total;

  // Checks
  `BDPC_ASSERT_NOW(a_skid_implies_out, buf_full, result_valid, "skid full with output empty")
  `BDPC_ASSERT_NEXT(a_accept_gives_result, accept, result_valid, "accepted beat lost")
  `BDPC_ASSERT_NOW(a_long_while_pressed, result_valid && (event_code == EV_LONG), pressed_level, "long press reported while released")
  `BDPC_ASSERT_NOW(a_double_while_released, result_valid && (event_code == EV_DOUBLE), !pressed_level, "double press reported while pressed")

endmodule

@@ tb/tb_button_debounce_press_classifier.sv @@
// Testbench for button_debounce_press_classifier: drives poll-tick beats, predicts
// debounced level, press events and totals per tick, and checks every result beat.
// Depends on bdpc_pkg and the block's top level, which needs the core, buffer and defines.
module tb_button_debounce_press_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import bdpc_pkg::*;

  localparam int TIMEOUT_NS     = 10_000_000;
  localparam int DRAIN_LIMIT    = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int MAX_REPORTS    = 10;

  // Indexes past the last register; writes there must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_LO = 8'h3C;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_HI = 8'hF8;

  // Directed tick patterns, sent MSB first
  localparam logic [20:0] TAPS_CLASSIFY = 21'b011111010000010100000;
  localparam logic [3:0]  TAPS_ZERO_LONG = 4'b1100;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  logic                      pressed_sample = 1'b0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic [1:0]                event_code;
  logic                      pressed_level;
  logic [TOTAL_BITS-1:0]     short_total;
  logic [TOTAL_BITS-1:0]     double_total;
  logic [TOTAL_BITS-1:0]     long_total;

  button_debounce_press_classifier u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .pressed_sample (pressed_sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .event_code     (event_code),
    .pressed_level  (pressed_level),
    .short_total    (short_total),
    .double_total   (double_total),
    .long_total     (long_total)
  );

  always #5 clk = ~clk;

  // Stimulus and checking bookkeeping
  logic       tick_samples[$];
  result_t    expected_results[$];
  int         offered_beats = 0;
  int         accepted_beats = 0;
  int         result_beats = 0;
  int         mismatch_count = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  int         holdoff_wanted = 0;
  int         holdoff_served = 0;
  int         holdoff_left = 0;

  // Predictor copy of the timing registers
  logic [DEBOUNCE_BITS-1:0] debounce_cfg = DEBOUNCE_RST;
  logic [TICKS_BITS-1:0]    startup_cfg  = STARTUP_RST;
  logic [TICKS_BITS-1:0]    window_cfg   = DOUBLE_WIN_RST;
  logic [TICKS_BITS-1:0]    long_cfg     = LONG_PRESS_RST;

  // Predictor state
  time_t  tick_count = '0;
  guard_t guard_ticks = '0;
  logic   levels_loaded = 1'b0;
  logic   raw_seen = 1'b0;
  logic   debounced = 1'b0;
  logic   long_done = 1'b0;
  logic   short_armed = 1'b0;
  time_t  raw_edge_tick = '0;
  time_t  press_tick = '0;
  time_t  release_tick = '0;
  count_t n_short = '0;
  count_t n_double = '0;
  count_t n_long = '0;

  function automatic time_t ticks_since(input time_t stamp);
    return tick_count - stamp;
  endfunction

  // One poll tick: advance time, debounce, classify, return the result beat
  function automatic result_t classify_tick(input logic sample);
    result_t r;
    event_t  ev;
    ev = EV_NONE;
    tick_count = tick_count + 1'b1;
    if (guard_ticks != GUARD_MAX) guard_ticks = guard_ticks + 1'b1;
    if (guard_ticks >= startup_cfg) begin
      if (!levels_loaded) begin
        // first tick past the guard takes the sample as both levels
        raw_seen = sample;
        debounced = sample;
        raw_edge_tick = tick_count;
        press_tick = sample ? tick_count : '0;
        levels_loaded = 1'b1;
      end else begin
        if (sample != raw_seen) begin
          raw_seen = sample;
          raw_edge_tick = tick_count;
        end
        if (raw_seen != debounced && ticks_since(raw_edge_tick) >= debounce_cfg) begin
          debounced = raw_seen;
          if (debounced) begin
            press_tick = tick_count;
            long_done = 1'b0;
          end else if (!long_done) begin
            // release: pair with a pending short, or arm one
            if (short_armed && ticks_since(release_tick) <= window_cfg) begin
              short_armed = 1'b0;
              n_double = n_double + 1'b1;
              ev = EV_DOUBLE;
            end else begin
              short_armed = 1'b1;
              release_tick = tick_count;
            end
          end
        end
        if (debounced && !long_done && ticks_since(press_tick) >= long_cfg) begin
          long_done = 1'b1;
          short_armed = 1'b0;
          n_long = n_long + 1'b1;
          ev = EV_LONG;
        end
        if (short_armed && !debounced && ticks_since(release_tick) > window_cfg) begin
          short_armed = 1'b0;
          n_short = n_short + 1'b1;
          ev = EV_SHORT;
        end
      end
    end
    r.event_code = ev;
    r.pressed_level = debounced;
    r.short_total = n_short;
    r.double_total = n_double;
    r.long_total = n_long;
    return r;
  endfunction

  function automatic logic send_idle();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 79;
      IDLE_BOTH: return $urandom_range(0, 99) < 14;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic recv_idle();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 79;
      IDLE_BOTH: return $urandom_range(0, 99) < 14;
      default:   return 1'b0;
    endcase
  endfunction

  // Register write; the predictor takes the value at once since the block is idle
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_DEBOUNCE:   debounce_cfg = data[DEBOUNCE_BITS-1:0];
      REG_STARTUP:    startup_cfg = data;
      REG_DOUBLE_WIN: window_cfg = data;
      REG_LONG_PRESS: long_cfg = data;
      default: ;
    endcase
  endtask

  // All four timing registers; junk in the unused debounce bits
  task automatic set_timing(input int deb, input int start, input int win, input int lng);
    write_reg(REG_DEBOUNCE, {8'($urandom), 8'(deb)});
    write_reg(REG_STARTUP, 16'(start));
    write_reg(REG_DOUBLE_WIN, 16'(win));
    write_reg(REG_LONG_PRESS, 16'(lng));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_level(input logic level, input int count);
    repeat (count) tick_samples.push_back(level);
  endtask

  // Press/release runs sized around the current timing, with bounces and noise
  task automatic queue_press_runs(input int n_items, input int run_cap);
    int   added;
    int   kind;
    int   len;
    int   deb;
    int   win;
    int   lng;
    logic level;
    deb = int'(debounce_cfg);
    win = int'(window_cfg);
    lng = int'(long_cfg);
    added = 0;
    level = 1'b0;
    while (added < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        len = $urandom_range(1, 8);
        repeat (len) tick_samples.push_back(1'($urandom_range(0, 1)));
      end else begin
        level = ~level;
        if (kind < 5) len = $urandom_range(1, (deb > 0) ? deb : 1);
        else if (kind < 12) len = $urandom_range(deb + 1, deb + 1 + win);
        else if (kind < 16) len = $urandom_range(deb + win + 2, deb + win + 12);
        else len = $urandom_range(deb + lng, deb + lng + 3);
        if (len > run_cap) len = run_cap;
        queue_level(level, len);
      end
      added += len;
    end
  endtask

  // Wait until every tick is taken and every result seen or the drain limit runs out, then let the block settle
  task automatic drain();
    int n;
    while (tick_samples.size() != 0 || accepted_beats != offered_beats) @(posedge clk);
    n = 0;
    while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sample driver: new beat only once the offered one has been taken
  always @(negedge clk) begin
    if (!rst && accepted_beats == offered_beats) begin
      if (tick_samples.size() != 0 && !send_idle()) begin
        pressed_sample <= tick_samples.pop_front();
        sample_valid <= 1'b1;
        offered_beats++;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result stall: random per phase, plus a long hold-off on request
  always @(negedge clk) begin
    if (holdoff_served != holdoff_wanted) begin
      holdoff_served = holdoff_wanted;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= recv_idle();
    end
  end

  // Monitor: check result beats, then predict for the sample beat taken at this edge
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result beat %0d arrived with no sample pending", result_beats);
        end else begin
          want = expected_results.pop_front();
          if (event_code !== want.event_code || pressed_level !== want.pressed_level ||
              short_total !== want.short_total || double_total !== want.double_total ||
              long_total !== want.long_total) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"result beat %0d mismatch (expected/actual): event %0d/%0d ",
                        "level %0d/%0d short %0d/%0d double %0d/%0d long %0d/%0d"},
                       result_beats, want.event_code, event_code,
                       want.pressed_level, pressed_level, want.short_total, short_total,
                       want.double_total, double_total, want.long_total, long_total);
          end
        end
        result_beats++;
      end
      if (sample_valid && !sample_stall) begin
        expected_results.push_back(classify_tick(pressed_sample));
        accepted_beats++;
      end
    end
  end

  // Phases of the run
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: guard, pressed load, long, short, double
    set_timing(0, 2, 3, 4);
    for (int i = $bits(TAPS_CLASSIFY) - 1; i >= 0; i--) tick_samples.push_back(TAPS_CLASSIFY[i]);
    drain();

    // Directed: zero long time reports on the press tick
    set_timing(1, 2, 3, 0);
    for (int i = $bits(TAPS_ZERO_LONG) - 1; i >= 0; i--) tick_samples.push_back(TAPS_ZERO_LONG[i]);
    drain();

    // Random, no idling
    set_timing(4, 0, 35, 60);
    idle_mode = IDLE_NONE;
    queue_press_runs(100, 400);
    drain();

    // Random, sender idling; zero debounce and window, long time just above zero
    set_timing(0, 0, 0, 1);
    idle_mode = IDLE_SEND;
    queue_press_runs(100, 400);
    drain();

    // Random, receiver stalling, with a long hold-off that backs up the input
    set_timing(2, 0, 10, 25);
    idle_mode = IDLE_RECV;
    holdoff_wanted++;
    queue_press_runs(100, 400);
    drain();

    // Random, both sides idling
    set_timing(1, 7, 5, 12);
    idle_mode = IDLE_BOTH;
    queue_press_runs(100, 400);
    drain();

    // Largest debounce, window and long times: one press and release held just past the longest debounce
    set_timing(255, 0, 65535, 65535);
    idle_mode = IDLE_NONE;
    queue_level(1'b1, int'(debounce_cfg) + 3);
    queue_level(1'b0, int'(debounce_cfg) + 3);
    drain();

    // Writes past the register map change nothing
    write_reg(REG_UNMAPPED_LO, 16'($urandom));
    write_reg(REG_UNMAPPED_HI, 16'($urandom));
    set_timing(3, 0, 20, 40);
    idle_mode = IDLE_BOTH;
    queue_press_runs(100, 400);
    drain();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (expected_results.size() != 0)
        $display("%0d expected results never arrived", expected_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bdpc_pkg.sv
rtl/core/bdpc_core.sv
rtl/core/bdpc_out_buf.sv
rtl/core/button_debounce_press_classifier.sv
tb/tb_button_debounce_press_classifier.sv
